// ===== hw/rtl/quadratic_congruential_xor_cipher_core_macros.svh =====
// Assertion macros for the quadratic congruential XOR cipher core checker.
`ifndef QUADRATIC_CONGRUENTIAL_XOR_CIPHER_CORE_MACROS_SVH
`define QUADRATIC_CONGRUENTIAL_XOR_CIPHER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define QCX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define QCX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qcx_pkg.sv =====
// Shared types and constants of the quadratic congruential XOR cipher core.
`default_nettype none

package qcx_pkg;

    localparam int unsigned POS_W      = 3;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned ADDR_W     = 6;

    localparam logic [63:0] SEED_RESET      = 64'd4095;
    localparam logic [31:0] MULT_D_RESET    = 32'd23894;
    localparam logic [31:0] LIN_A_RESET     = 32'd1;
    localparam logic [31:0] ADD_C_RESET     = 32'd1767567;
    localparam logic [31:0] MODULUS_N_RESET = 32'd1875814;
    localparam logic [63:0] BLOCK_STEP      = 64'd31;

    // register index, paddr[5:3]
    typedef enum logic [2:0] {
        REG_SEED      = 3'd0,
        REG_MULT_D    = 3'd1,
        REG_LIN_A     = 3'd2,
        REG_ADD_C     = 3'd3,
        REG_MODULUS_N = 3'd4
    } reg_idx_t;

    // what the back end must do before it can use this byte
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_SEED = 2'd1,
        KIND_NEXT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        kind_t            kind;
    } entry_t;

    typedef struct packed {
        logic [31:0] mult_d;
        logic [31:0] lin_a;
        logic [31:0] add_c;
        logic [31:0] modulus_n;
    } coef_t;

    typedef struct packed {
        logic        done;
        logic [63:0] word;
    } kg_rsp_t;

    function automatic logic [7:0] key_byte(logic [63:0] w, logic [POS_W-1:0] pos);
        return w[{pos, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/quadratic_congruential_xor_cipher_core.sv =====
// Top level of the quadratic congruential XOR cipher core.
//
//   channel  | signals                              | carries
//   ---------+--------------------------------------+-------------------------------
//   s_*      | s_tvalid s_tready s_tdata[7:0]       | input word: data_byte
//   m_*      | m_tvalid m_tready m_tdata[7:0]       | output word: out_byte
//   apb      | psel penable pwrite paddr pwdata ... | seed, mult_d, lin_a, add_c, n
//
// A byte inside a key word uses the current key word. The first byte of a block
// takes one 64-bit add (seed plus 31 per finished block). The first byte of any other
// word takes 7 steps on the shared 32x32 multiplier, then the
// 2-bit-per-cycle remainder unit (none when modulus_n is zero).
// Reset clears counters, state and registers; no clearing pass. A 4-deep queue
// lets the input keep taking words while the key unit runs or m_tready is low.
`default_nettype none

module quadratic_congruential_xor_cipher_core #(
    parameter int unsigned WORDS_PER_BLOCK = 32,
    parameter int unsigned BYTES_PER_WORD  = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] data_byte
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] out_byte
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [qcx_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]                pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);

    logic [63:0]       seed_reg;
    logic [31:0]       mult_d_reg, lin_a_reg, add_c_reg, modulus_n_reg;
    logic              wr_en;
    qcx_pkg::reg_idx_t reg_idx;
    qcx_pkg::coef_t    coef;
    qcx_pkg::entry_t   push_entry, head;
    logic              push, pop, fifo_full, fifo_empty;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = qcx_pkg::reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= qcx_pkg::SEED_RESET;
            mult_d_reg    <= qcx_pkg::MULT_D_RESET;
            lin_a_reg     <= qcx_pkg::LIN_A_RESET;
            add_c_reg     <= qcx_pkg::ADD_C_RESET;
            modulus_n_reg <= qcx_pkg::MODULUS_N_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                qcx_pkg::REG_SEED:      seed_reg      <= pwdata;
                qcx_pkg::REG_MULT_D:    mult_d_reg    <= pwdata[31:0];
                qcx_pkg::REG_LIN_A:     lin_a_reg     <= pwdata[31:0];
                qcx_pkg::REG_ADD_C:     add_c_reg     <= pwdata[31:0];
                qcx_pkg::REG_MODULUS_N: modulus_n_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            qcx_pkg::REG_SEED:      prdata = seed_reg;
            qcx_pkg::REG_MULT_D:    prdata = {32'd0, mult_d_reg};
            qcx_pkg::REG_LIN_A:     prdata = {32'd0, lin_a_reg};
            qcx_pkg::REG_ADD_C:     prdata = {32'd0, add_c_reg};
            qcx_pkg::REG_MODULUS_N: prdata = {32'd0, modulus_n_reg};
            default:                prdata = '0;
        endcase
    end

    assign coef.mult_d    = mult_d_reg;
    assign coef.lin_a     = lin_a_reg;
    assign coef.add_c     = add_c_reg;
    assign coef.modulus_n = modulus_n_reg;

    qcx_front #(
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
        .BYTES_PER_WORD  (BYTES_PER_WORD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry)
    );

    qcx_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (fifo_full),
        .empty      (fifo_empty)
    );

    qcx_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (fifo_empty),
        .pop      (pop),
        .seed     (seed_reg),
        .coef     (coef),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/qcx_front.sv =====
// Front end: accepts input words and tags each with its key position and load kind.
`default_nettype none

module qcx_front #(
    parameter int unsigned WORDS_PER_BLOCK = 32,
    parameter int unsigned BYTES_PER_WORD  = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,
    input  wire logic            fifo_full,
    output logic                 push,
    output qcx_pkg::entry_t      push_entry
);

    localparam int unsigned BIW = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;
    localparam int unsigned WIW = $clog2(WORDS_PER_BLOCK);

    logic [BIW-1:0] byte_idx_reg, byte_idx_next;
    logic [WIW-1:0] word_idx_reg, word_idx_next;
    logic           last_byte, last_word;

    assign s_tready  = !fifo_full;
    assign push      = s_tvalid && s_tready;
    assign last_byte = (byte_idx_reg == BIW'(BYTES_PER_WORD - 1));
    assign last_word = (word_idx_reg == WIW'(WORDS_PER_BLOCK - 1));

    always_comb
    begin
        push_entry.data = s_tdata;
        push_entry.pos  = qcx_pkg::POS_W'(byte_idx_reg);
        if (byte_idx_reg != '0)
        begin
            push_entry.kind = qcx_pkg::KIND_NONE;
        end
        else if (word_idx_reg == '0)
        begin
            push_entry.kind = qcx_pkg::KIND_SEED;
        end
        else
        begin
            push_entry.kind = qcx_pkg::KIND_NEXT;
        end
    end

    always_comb
    begin
        byte_idx_next = byte_idx_reg;
        word_idx_next = word_idx_reg;
        if (push)
        begin
            if (last_byte)
            begin
                byte_idx_next = '0;
                word_idx_next = last_word ? '0 : word_idx_reg + 1'b1;
            end
            else
            begin
                byte_idx_next = byte_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg <= '0;
            word_idx_reg <= '0;
        end
        else
        begin
            byte_idx_reg <= byte_idx_next;
            word_idx_reg <= word_idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/qcx_fifo.sv =====
// Short queue between the front end and the back end.
`default_nettype none

module qcx_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire qcx_pkg::entry_t push_entry,
    input  wire logic            pop,
    output qcx_pkg::entry_t      head,
    output logic                 full,
    output logic                 empty
);

    localparam int unsigned AW = qcx_pkg::FIFO_AW;

    qcx_pkg::entry_t mem_reg [qcx_pkg::FIFO_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg, count_next;

    assign full  = (count_reg == (AW + 1)'(qcx_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/qcx_keygen.sv =====
// Next key word: d*x*x + a*x + c mod 2^64 on one 32x32 multiplier, then mod n, 2 bits a cycle.
`default_nettype none

module qcx_keygen (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [63:0]     x,
    input  wire qcx_pkg::coef_t  coef,
    output qcx_pkg::kg_rsp_t     rsp
);

    typedef enum logic [2:0] {
        KG_IDLE = 3'b001,
        KG_MUL  = 3'b010,
        KG_DIV  = 3'b100
    } kg_state_t;

    localparam logic [2:0] LAST_STEP = 3'd6;
    localparam logic [4:0] LAST_DIV  = 5'd31;

    kg_state_t   state_reg, state_next;
    logic [2:0]  step_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] x_reg, prod_reg, sq_reg, acc_reg, dvd_reg, word_reg;
    logic [31:0] rem_reg;
    logic        done_reg;

    logic [31:0] opa, opb;
    logic [63:0] acc_fin;
    logic [32:0] t1, t2, nn;
    logic [31:0] r1, r2;

    // operand schedule: x*x (two parts), d*sq (two parts), a*x (two parts)
    always_comb
    begin
        unique case (step_reg)
            3'd0:    begin opa = x_reg[31:0];   opb = x_reg[31:0];   end
            3'd1:    begin opa = x_reg[31:0];   opb = x_reg[63:32];  end
            3'd2:    begin opa = coef.mult_d;   opb = sq_reg[31:0];  end
            3'd3:    begin opa = coef.mult_d;   opb = sq_reg[63:32]; end
            3'd4:    begin opa = coef.lin_a;    opb = x_reg[31:0];   end
            3'd5:    begin opa = coef.lin_a;    opb = x_reg[63:32];  end
            default: begin opa = '0;            opb = '0;            end
        endcase
    end

    assign acc_fin = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};

    // two restoring steps of the remainder
    assign nn = {1'b0, coef.modulus_n};
    always_comb
    begin
        t1 = {rem_reg, dvd_reg[63]};
        if (t1 >= nn)
        begin
            t1 = t1 - nn;
        end
        r1 = t1[31:0];
        t2 = {r1, dvd_reg[62]};
        if (t2 >= nn)
        begin
            t2 = t2 - nn;
        end
        r2 = t2[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            KG_IDLE: if (start) state_next = KG_MUL;
            KG_MUL:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = (coef.modulus_n == '0) ? KG_IDLE : KG_DIV;
                end
            end
            KG_DIV:  if (cnt_reg == LAST_DIV) state_next = KG_IDLE;
            default: state_next = KG_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        if (state_reg == KG_IDLE && start)
        begin
            x_reg <= x;
        end
        if (state_reg == KG_MUL)
        begin
            unique case (step_reg)
                3'd1:    sq_reg <= prod_reg;
                3'd2:    sq_reg[63:32] <= sq_reg[63:32] + {prod_reg[30:0], 1'b0};
                3'd3:    acc_reg <= prod_reg + {32'd0, coef.add_c};
                3'd4:    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                3'd5:    acc_reg <= acc_reg + prod_reg;
                3'd6:
                begin
                    dvd_reg  <= acc_fin;
                    rem_reg  <= '0;
                    word_reg <= acc_fin;
                end
                default: ;
            endcase
        end
        if (state_reg == KG_DIV)
        begin
            rem_reg  <= r2;
            dvd_reg  <= {dvd_reg[61:0], 2'b00};
            word_reg <= {32'd0, r2};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= KG_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg != KG_IDLE) && (state_next == KG_IDLE);
            step_reg  <= (state_reg == KG_MUL) ? step_reg + 1'b1 : '0;
            cnt_reg   <= (state_reg == KG_DIV) ? cnt_reg + 1'b1 : '0;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.word = word_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/qcx_back.sv =====
// Back end: loads key words, XORs each byte, and holds the result in the output register.
`default_nettype none

module qcx_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire qcx_pkg::entry_t head,
    input  wire logic            empty,
    output logic                 pop,
    input  wire logic [63:0]     seed,
    input  wire qcx_pkg::coef_t  coef,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_WAIT = 3'b010,
        B_EMIT = 3'b100
    } b_state_t;

    b_state_t                  state_reg, state_next;
    logic [63:0]               word_reg, base_reg, seed_word;
    logic [7:0]                hold_data_reg, out_reg, out_next;
    logic [qcx_pkg::POS_W-1:0] hold_pos_reg;
    logic                      valid_reg, out_free, out_load, kg_start;
    qcx_pkg::kg_rsp_t          kg_rsp;

    assign out_free  = !valid_reg || m_tready;
    assign seed_word = seed + base_reg;
    assign pop       = (state_reg == B_IDLE) && !empty && out_free;
    assign kg_start  = pop && (head.kind == qcx_pkg::KIND_NEXT);

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        out_next   = head.data ^ qcx_pkg::key_byte(word_reg, head.pos);
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    unique case (head.kind)
                        qcx_pkg::KIND_SEED:
                        begin
                            out_load = 1'b1;
                            out_next = head.data ^ qcx_pkg::key_byte(seed_word, head.pos);
                        end
                        qcx_pkg::KIND_NEXT: state_next = B_WAIT;
                        default:            out_load = 1'b1;
                    endcase
                end
            end
            B_WAIT: if (kg_rsp.done) state_next = B_EMIT;
            B_EMIT:
            begin
                out_next = hold_data_reg ^ qcx_pkg::key_byte(word_reg, hold_pos_reg);
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
        if (kg_start)
        begin
            hold_data_reg <= head.data;
            hold_pos_reg  <= head.pos;
        end
    end

    // base_reg tracks 31 * blocks started
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
            base_reg  <= '0;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
            if (pop && head.kind == qcx_pkg::KIND_SEED)
            begin
                word_reg <= seed_word;
                base_reg <= base_reg + qcx_pkg::BLOCK_STEP;
            end
            else if (state_reg == B_WAIT && kg_rsp.done)
            begin
                word_reg <= kg_rsp.word;
            end
        end
    end

    qcx_keygen u_keygen (
        .clk   (clk),
        .rst_n (rst_n),
        .start (kg_start),
        .x     (word_reg),
        .coef  (coef),
        .rsp   (kg_rsp)
    );

    assign m_tvalid = valid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/qcx_checker.sv =====
// Port-level checker for the cipher core, bound to the top level.
`default_nettype none

`include "quadratic_congruential_xor_cipher_core_macros.svh"

module qcx_port_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic [7:0]                 s_tdata,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [7:0]                 m_tdata,
    input wire logic                       psel,
    input wire logic                       penable,
    input wire logic                       pwrite,
    input wire logic [qcx_pkg::ADDR_W-1:0] paddr,
    input wire logic [63:0]                pwdata,
    input wire logic [63:0]                prdata,
    input wire logic                       pready
);

    // queue, one held byte and the output register
    localparam logic [3:0] MAX_OPEN = 4'(qcx_pkg::FIFO_DEPTH + 2);
    localparam logic [3:0] FULL_Q   = 4'(qcx_pkg::FIFO_DEPTH);

    logic [3:0] open_reg;
    logic       s_acc, m_acc, unused;

    assign s_acc  = s_tvalid && s_tready;
    assign m_acc  = m_tvalid && m_tready;
    assign unused = ^{s_tdata, psel, penable, pwrite, paddr, pwdata, prdata, pready};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + 4'(s_acc) - 4'(m_acc);
        end
    end

    `QCX_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
    `QCX_ASSERT_IMP(a_no_orphan, m_tvalid, open_reg != 4'd0, "output word with no input word outstanding")
    `QCX_ASSERT_IMP(a_open_bound, 1'b1, open_reg <= MAX_OPEN, "more words in flight than the core can hold")
    `QCX_ASSERT_IMP(a_ready_low, !s_tready, open_reg >= FULL_Q, "input stalled while the queue has room")

endmodule

bind quadratic_congruential_xor_cipher_core qcx_port_checker u_qcx_checker (.*);

`default_nettype wire
